// ===== hdl/image_resize_bilinear_nearest_defines.svh =====
// ----------------------------------------------------------------------------
// image resize assertion macros
// concurrent checks on clk, disabled while arst_n is low
// ----------------------------------------------------------------------------
`ifndef IMAGE_RESIZE_BILINEAR_NEAREST_DEFINES_SVH
`define IMAGE_RESIZE_BILINEAR_NEAREST_DEFINES_SVH

// same-cycle implication
`define IRBN_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define IRBN_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/irbn_pkg.sv =====
// ----------------------------------------------------------------------------
// irbn_pkg
// shared types and constants of the image resize pipeline
// ----------------------------------------------------------------------------
package irbn_pkg;

	localparam int MAX_SRC_WIDTH_DEF  = 256;
	localparam int MAX_SRC_HEIGHT_DEF = 256;
	localparam int MAX_COMPONENTS_DEF = 4;

	localparam int COORD_W    = 12;
	localparam int DST_W      = 13;
	localparam int PIX_W      = 32;
	localparam int FRAC_W     = 8;
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 13;

	localparam logic CMD_WRITE       = 1'b0;
	localparam logic CMD_REQUEST     = 1'b1;
	localparam logic FILTER_NEAREST  = 1'b0;
	localparam logic FILTER_BILINEAR = 1'b1;

	localparam logic [CFG_ADDR_W-1:0] REG_SRC_WIDTH  = 3'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_SRC_HEIGHT = 3'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_DST_WIDTH  = 3'd2;
	localparam logic [CFG_ADDR_W-1:0] REG_DST_HEIGHT = 3'd3;
	localparam logic [CFG_ADDR_W-1:0] REG_COMPONENTS = 3'd4;
	localparam logic [CFG_ADDR_W-1:0] REG_FILTER     = 3'd5;

	// per-stage control that travels with each beat
	typedef struct packed {
		logic vld;
		logic req;
	} ctl_t;

	typedef struct packed {
		logic [8:0]  src_width;
		logic [8:0]  src_height;
		logic [12:0] dst_width;
		logic [12:0] dst_height;
		logic [2:0]  components;
		logic        filter_mode;
	} cfg_t;

endpackage

// ===== hdl/irbn_div.sv =====
// ----------------------------------------------------------------------------
// irbn_div
// pipelined restoring divider, two lanes, one quotient bit per stage
// ----------------------------------------------------------------------------
module irbn_div import irbn_pkg::*; #(
	parameter int NW  = 29,
	parameter int DW  = 13,
	parameter int QW  = 16,
	parameter int SBW = 8
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  ctl_t           ctl_in,
	input  logic [SBW-1:0] side_in,
	input  logic [NW-1:0]  num_x,
	input  logic [DW-1:0]  den_x,
	input  logic [NW-1:0]  num_y,
	input  logic [DW-1:0]  den_y,
	output ctl_t           ctl_out,
	output logic [SBW-1:0] side_out,
	output logic [QW-1:0]  quo_x,
	output logic [QW-1:0]  quo_y
);

	ctl_t           ctl_sn   [QW+1];
	logic [SBW-1:0] side_sn  [QW+1];
	logic [DW-1:0]  rem_x_sn [QW+1];
	logic [QW-1:0]  nq_x_sn  [QW+1];
	logic [DW-1:0]  den_x_sn [QW+1];
	logic [DW-1:0]  rem_y_sn [QW+1];
	logic [QW-1:0]  nq_y_sn  [QW+1];
	logic [DW-1:0]  den_y_sn [QW+1];

	// remainder and numerator/quotient shift word after one bit
	function automatic logic [DW+QW-1:0] div_step(input logic [DW-1:0] r,
		input logic [QW-1:0] nq, input logic [DW-1:0] d);
		logic [DW:0] t;
		logic [DW:0] diff;
		t    = {r, nq[QW-1]};
		diff = t - {1'b0, d};
		if (t >= {1'b0, d}) begin
			return {diff[DW-1:0], nq[QW-2:0], 1'b1};
		end else begin
			return {t[DW-1:0], nq[QW-2:0], 1'b0};
		end
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= QW; i++) begin
				ctl_sn[i] <= '0;
			end
		end else if (en) begin
			ctl_sn[0] <= ctl_in;
			for (int i = 0; i < QW; i++) begin
				ctl_sn[i+1] <= ctl_sn[i];
			end
		end
	end

	// quotient is known to fit QW bits, so the top part starts below the divisor
	always_ff @(posedge clk) begin
		if (en) begin
			side_sn[0]  <= side_in;
			rem_x_sn[0] <= DW'(num_x >> QW);
			nq_x_sn[0]  <= num_x[QW-1:0];
			den_x_sn[0] <= den_x;
			rem_y_sn[0] <= DW'(num_y >> QW);
			nq_y_sn[0]  <= num_y[QW-1:0];
			den_y_sn[0] <= den_y;
		end
	end

	for (genvar i = 0; i < QW; i++) begin : g_stage
		logic [DW+QW-1:0] nx;
		logic [DW+QW-1:0] ny;
		always_comb begin
			nx = div_step(rem_x_sn[i], nq_x_sn[i], den_x_sn[i]);
			ny = div_step(rem_y_sn[i], nq_y_sn[i], den_y_sn[i]);
		end
		always_ff @(posedge clk) begin
			if (en) begin
				side_sn[i+1]  <= side_sn[i];
				rem_x_sn[i+1] <= nx[DW+QW-1:QW];
				nq_x_sn[i+1]  <= nx[QW-1:0];
				den_x_sn[i+1] <= den_x_sn[i];
				rem_y_sn[i+1] <= ny[DW+QW-1:QW];
				nq_y_sn[i+1]  <= ny[QW-1:0];
				den_y_sn[i+1] <= den_y_sn[i];
			end
		end
	end

	assign ctl_out  = ctl_sn[QW];
	assign side_out = side_sn[QW];
	assign quo_x    = nq_x_sn[QW];
	assign quo_y    = nq_y_sn[QW];

endmodule

// ===== hdl/irbn_bank.sv =====
// ----------------------------------------------------------------------------
// irbn_bank
// one frame store bank, one write and one registered read per cycle while en is high
// ----------------------------------------------------------------------------
module irbn_bank import irbn_pkg::*; #(
	parameter int AW = 14,
	parameter int CW = 32
) (
	input  logic          clk,
	input  logic          en,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [CW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [CW-1:0] rdata
);

	logic [CW-1:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[waddr] <= wdata;
			end
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hdl/irbn_blend.sv =====
// ----------------------------------------------------------------------------
// irbn_blend
// two-stage bilinear blend per component, horizontal then vertical
// ----------------------------------------------------------------------------
module irbn_blend import irbn_pkg::*; #(
	parameter int NCOMP = 4,
	parameter int NCW   = 3
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  ctl_t               ctl_in,
	input  logic [8*NCOMP-1:0] tl,
	input  logic [8*NCOMP-1:0] tr,
	input  logic [8*NCOMP-1:0] bl,
	input  logic [8*NCOMP-1:0] br,
	input  logic [FRAC_W-1:0]  fx,
	input  logic [FRAC_W-1:0]  fy,
	input  logic [NCW-1:0]     nc,
	output ctl_t               ctl_out,
	output logic [PIX_W-1:0]   pixel_out
);

	ctl_t              ctl_s5;
	ctl_t              ctl_s6;
	logic [15:0]       top_s5 [NCOMP];
	logic [15:0]       bot_s5 [NCOMP];
	logic [FRAC_W-1:0] fy_s5;
	logic [PIX_W-1:0]  pix_s6;
	logic [15:0]       top_c  [NCOMP];
	logic [15:0]       bot_c  [NCOMP];
	logic [PIX_W-1:0]  pix_c;
	logic [8:0]        wfx;
	logic [8:0]        wfy;

	always_comb begin
		logic [16:0] st;
		logic [16:0] sb;
		wfx = 9'd256 - {1'b0, fx};
		for (int k = 0; k < NCOMP; k++) begin
			st = tl[8*k +: 8] * wfx + tr[8*k +: 8] * fx;
			sb = bl[8*k +: 8] * wfx + br[8*k +: 8] * fx;
			top_c[k] = st[15:0];
			bot_c[k] = sb[15:0];
		end
	end

	always_comb begin
		logic [24:0] acc;
		wfy   = 9'd256 - {1'b0, fy_s5};
		pix_c = '0;
		for (int k = 0; k < NCOMP; k++) begin
			acc = top_s5[k] * wfy + bot_s5[k] * fy_s5;
			if (k < int'(nc)) begin
				pix_c[8*k +: 8] = acc[23:16];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s5 <= '0;
			ctl_s6 <= '0;
		end else if (en) begin
			ctl_s5 <= ctl_in;
			ctl_s6 <= ctl_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			top_s5 <= top_c;
			bot_s5 <= bot_c;
			fy_s5  <= fy;
			pix_s6 <= pix_c;
		end
	end

	assign ctl_out   = ctl_s6;
	assign pixel_out = pix_s6;

endmodule

// ===== hdl/image_resize_bilinear_nearest.sv =====
// from accept a beat passes the input register, the pipelined divider, the read
// address register, the bank read and the blend stages; the divider sets the depth
// throughput: one beat per cycle; a result not taken stalls the whole pipeline
// reset: configuration returns to its reset values and the pipeline empties at once
// the frame store is not cleared; read an entry only after writing it
`include "image_resize_bilinear_nearest_defines.svh"
// ----------------------------------------------------------------------------
// image_resize_bilinear_nearest
// frame store scaler with nearest and bilinear filters, fully pipelined
// ----------------------------------------------------------------------------
module image_resize_bilinear_nearest import irbn_pkg::*; #(
	parameter int MAX_SRC_WIDTH  = MAX_SRC_WIDTH_DEF,
	parameter int MAX_SRC_HEIGHT = MAX_SRC_HEIGHT_DEF,
	parameter int MAX_COMPONENTS = MAX_COMPONENTS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  command,
	input  logic [COORD_W-1:0]    coord_x,
	input  logic [COORD_W-1:0]    coord_y,
	input  logic [PIX_W-1:0]      pixel_in,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [PIX_W-1:0]      pixel_out,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int XW  = $clog2(MAX_SRC_WIDTH);
	localparam int YW  = $clog2(MAX_SRC_HEIGHT);
	localparam int SWW = $clog2(MAX_SRC_WIDTH + 1);
	localparam int SHW = $clog2(MAX_SRC_HEIGHT + 1);
	localparam int SZW = (SWW > SHW) ? SWW : SHW;
	localparam int MW  = (XW > YW) ? XW : YW;
	localparam int QW  = MW + FRAC_W;
	localparam int NW  = COORD_W + SZW + FRAC_W;
	localparam int DW  = DST_W;
	localparam int CW  = 8 * MAX_COMPONENTS;
	localparam int NCW = $clog2(MAX_COMPONENTS + 1);
	localparam int XAW = (XW > 1) ? XW - 1 : 1;
	localparam int YAW = (YW > 1) ? YW - 1 : 1;
	localparam int AW  = XAW + YAW;
	localparam int SBW = 1 + 2 + AW + CW;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.src_width   <= 9'd1;
			cfg_q.src_height  <= 9'd1;
			cfg_q.dst_width   <= 13'd1;
			cfg_q.dst_height  <= 13'd1;
			cfg_q.components  <= 3'd4;
			cfg_q.filter_mode <= FILTER_NEAREST;
		end else if (cfg_valid) begin
			unique case (cfg_addr)
				REG_SRC_WIDTH:  cfg_q.src_width   <= cfg_data[8:0];
				REG_SRC_HEIGHT: cfg_q.src_height  <= cfg_data[8:0];
				REG_DST_WIDTH:  cfg_q.dst_width   <= cfg_data[12:0];
				REG_DST_HEIGHT: cfg_q.dst_height  <= cfg_data[12:0];
				REG_COMPONENTS: cfg_q.components  <= cfg_data[2:0];
				REG_FILTER:     cfg_q.filter_mode <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign cfg_ready = 1'b1;

	// effective sizes, saturated to their legal ranges
	logic [SZW-1:0] sw_eff, sh_eff, swm1, shm1;
	logic [DW-1:0]  dw_eff, dh_eff, dwm1, dhm1;
	logic [NCW-1:0] nc_eff;
	logic           bil;

	always_comb begin
		if (cfg_q.src_width == '0) begin
			sw_eff = SZW'(1);
		end else if (int'(cfg_q.src_width) > MAX_SRC_WIDTH) begin
			sw_eff = SZW'(MAX_SRC_WIDTH);
		end else begin
			sw_eff = SZW'(cfg_q.src_width);
		end
		if (cfg_q.src_height == '0) begin
			sh_eff = SZW'(1);
		end else if (int'(cfg_q.src_height) > MAX_SRC_HEIGHT) begin
			sh_eff = SZW'(MAX_SRC_HEIGHT);
		end else begin
			sh_eff = SZW'(cfg_q.src_height);
		end
		if (cfg_q.components == '0) begin
			nc_eff = NCW'(1);
		end else if (int'(cfg_q.components) > MAX_COMPONENTS) begin
			nc_eff = NCW'(MAX_COMPONENTS);
		end else begin
			nc_eff = NCW'(cfg_q.components);
		end
		dw_eff = (cfg_q.dst_width == '0) ? DW'(1) : cfg_q.dst_width;
		dh_eff = (cfg_q.dst_height == '0) ? DW'(1) : cfg_q.dst_height;
		swm1   = sw_eff - 1'b1;
		shm1   = sh_eff - 1'b1;
		dwm1   = dw_eff - 1'b1;
		dhm1   = dh_eff - 1'b1;
		bil    = (cfg_q.filter_mode == FILTER_BILINEAR);
	end

	logic en;
	ctl_t blend_ctl;

	assign en       = !(blend_ctl.vld && blend_ctl.req) || out_ready;
	assign in_ready = en;

	// input register
	ctl_t               ctl_s1;
	logic [COORD_W-1:0] cx_s1, cy_s1;
	logic [CW-1:0]      pix_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (en) begin
			ctl_s1.vld <= in_valid;
			ctl_s1.req <= (command == CMD_REQUEST);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cx_s1  <= coord_x;
			cy_s1  <= coord_y;
			pix_s1 <= pixel_in[CW-1:0];
		end
	end

	// clamp, scale and pick the divisor
	logic [COORD_W-1:0]     cxc, cyc;
	logic [SZW-1:0]         mx, my;
	logic [COORD_W+SZW-1:0] prod_x, prod_y;
	logic [NW-1:0]          num_x, num_y;
	logic [DW-1:0]          den_x, den_y;
	logic                   we_c;
	logic [1:0]             wbank_c;
	logic [AW-1:0]          waddr_c;

	always_comb begin
		cxc    = ({1'b0, cx_s1} > dwm1) ? dwm1[COORD_W-1:0] : cx_s1;
		cyc    = ({1'b0, cy_s1} > dhm1) ? dhm1[COORD_W-1:0] : cy_s1;
		mx     = bil ? sw_eff : swm1;
		my     = bil ? sh_eff : shm1;
		prod_x = cxc * mx;
		prod_y = cyc * my;
		num_x  = bil ? {prod_x, FRAC_W'(0)} : NW'(prod_x);
		num_y  = bil ? {prod_y, FRAC_W'(0)} : NW'(prod_y);
		den_x  = bil ? dw_eff : ((dwm1 == '0) ? DW'(1) : dwm1);
		den_y  = bil ? dh_eff : ((dhm1 == '0) ? DW'(1) : dhm1);
		we_c   = !ctl_s1.req && (int'(cx_s1) < MAX_SRC_WIDTH)
			&& (int'(cy_s1) < MAX_SRC_HEIGHT);
		wbank_c = {cy_s1[0], cx_s1[0]};
		waddr_c = {YAW'(cy_s1[YW-1:0] >> 1), XAW'(cx_s1[XW-1:0] >> 1)};
	end

	ctl_t           div_ctl;
	logic [SBW-1:0] div_side;
	logic [QW-1:0]  quo_x, quo_y;

	irbn_div #(
		.NW  (NW),
		.DW  (DW),
		.QW  (QW),
		.SBW (SBW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.ctl_in   (ctl_s1),
		.side_in  ({we_c, wbank_c, waddr_c, pix_s1}),
		.num_x    (num_x),
		.den_x    (den_x),
		.num_y    (num_y),
		.den_y    (den_y),
		.ctl_out  (div_ctl),
		.side_out (div_side),
		.quo_x    (quo_x),
		.quo_y    (quo_y)
	);

	logic          we_d;
	logic [1:0]    wbank_d;
	logic [AW-1:0] waddr_d;
	logic [CW-1:0] wdata_d;

	assign {we_d, wbank_d, waddr_d, wdata_d} = div_side;

	// source neighbours and weights
	logic [MW-1:0]     xi, yi;
	logic [XW:0]       xn;
	logic [YW:0]       yn;
	logic [XW-1:0]     x0_c, x1_c;
	logic [YW-1:0]     y0_c, y1_c;
	logic [FRAC_W-1:0] fx_c, fy_c;

	always_comb begin
		if (bil) begin
			xi   = MW'(quo_x >> FRAC_W);
			yi   = MW'(quo_y >> FRAC_W);
			fx_c = quo_x[FRAC_W-1:0];
			fy_c = quo_y[FRAC_W-1:0];
		end else begin
			xi   = MW'(quo_x);
			yi   = MW'(quo_y);
			fx_c = '0;
			fy_c = '0;
		end
		x0_c = (xi > swm1) ? XW'(swm1) : XW'(xi);
		y0_c = (yi > shm1) ? YW'(shm1) : YW'(yi);
		xn   = (XW + 1)'(x0_c) + 1'b1;
		yn   = (YW + 1)'(y0_c) + 1'b1;
		// nearest reads one pixel only
		x1_c = !bil ? x0_c : ((xn < sw_eff) ? XW'(xn) : XW'(swm1));
		y1_c = !bil ? y0_c : ((yn < sh_eff) ? YW'(yn) : YW'(shm1));
	end

	// bilinear, off the edges: each parity bank sees exactly one of the four neighbours
	logic [AW-1:0] raddr_c [4];

	for (genvar b = 0; b < 4; b++) begin : g_raddr
		logic [XW-1:0] xs;
		logic [YW-1:0] ys;
		always_comb begin
			xs = (x0_c[0] == b[0]) ? x0_c : x1_c;
			ys = (y0_c[0] == b[1]) ? y0_c : y1_c;
			raddr_c[b] = {YAW'(ys >> 1), XAW'(xs >> 1)};
		end
	end

	ctl_t              ctl_s3;
	logic [AW-1:0]     raddr_s3 [4];
	logic [XW-1:0]     x0_s3, x1_s3;
	logic [YW-1:0]     y0_s3, y1_s3;
	logic [FRAC_W-1:0] fx_s3, fy_s3;
	logic              we_s3;
	logic [1:0]        wbank_s3;
	logic [AW-1:0]     waddr_s3;
	logic [CW-1:0]     wdata_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s3 <= '0;
		end else if (en) begin
			ctl_s3 <= div_ctl;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			raddr_s3 <= raddr_c;
			x0_s3    <= x0_c;
			x1_s3    <= x1_c;
			y0_s3    <= y0_c;
			y1_s3    <= y1_c;
			fx_s3    <= fx_c;
			fy_s3    <= fy_c;
			we_s3    <= we_d;
			wbank_s3 <= wbank_d;
			waddr_s3 <= waddr_d;
			wdata_s3 <= wdata_d;
		end
	end

	logic [CW-1:0] rdata [4];

	for (genvar b = 0; b < 4; b++) begin : g_bank
		irbn_bank #(
			.AW (AW),
			.CW (CW)
		) u_bank (
			.clk   (clk),
			.en    (en),
			.we    (ctl_s3.vld && we_s3 && (wbank_s3 == 2'(b))),
			.waddr (waddr_s3),
			.wdata (wdata_s3),
			.raddr (raddr_s3[b]),
			.rdata (rdata[b])
		);
	end

	ctl_t              ctl_s4;
	logic              x0p_s4, x1p_s4, y0p_s4, y1p_s4;
	logic [FRAC_W-1:0] fx_s4, fy_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s4 <= '0;
		end else if (en) begin
			ctl_s4 <= ctl_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x0p_s4 <= x0_s3[0];
			x1p_s4 <= x1_s3[0];
			y0p_s4 <= y0_s3[0];
			y1p_s4 <= y1_s3[0];
			fx_s4  <= fx_s3;
			fy_s4  <= fy_s3;
		end
	end

	logic [CW-1:0] tl, tr, bl, br;

	assign tl = rdata[{y0p_s4, x0p_s4}];
	assign tr = rdata[{y0p_s4, x1p_s4}];
	assign bl = rdata[{y1p_s4, x0p_s4}];
	assign br = rdata[{y1p_s4, x1p_s4}];

	irbn_blend #(
		.NCOMP (MAX_COMPONENTS),
		.NCW   (NCW)
	) u_blend (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.ctl_in    (ctl_s4),
		.tl        (tl),
		.tr        (tr),
		.bl        (bl),
		.br        (br),
		.fx        (fx_s4),
		.fy        (fy_s4),
		.nc        (nc_eff),
		.ctl_out   (blend_ctl),
		.pixel_out (pixel_out)
	);

	assign out_valid = blend_ctl.vld && blend_ctl.req;

	`IRBN_ASSERT_IMP(a_x_neigh, ctl_s3.vld && ctl_s3.req, (x0_s3 < sw_eff) && (x1_s3 >= x0_s3) && (x1_s3 - x0_s3 <= 1), "column neighbours out of range")
	`IRBN_ASSERT_IMP(a_y_neigh, ctl_s3.vld && ctl_s3.req, (y0_s3 < sh_eff) && (y1_s3 >= y0_s3) && (y1_s3 - y0_s3 <= 1), "row neighbours out of range")
	`IRBN_ASSERT_IMP(a_nearest_pt, ctl_s3.vld && !bil, (fx_s3 == '0) && (fy_s3 == '0) && (x1_s3 == x0_s3) && (y1_s3 == y0_s3), "nearest beat carries a blend")
	`IRBN_ASSERT_NXT(a_unused_bytes, out_valid, !out_valid || ((pixel_out >> (nc_eff * 8)) == '0), "unused component bytes not zero")

endmodule
